// ===== design/jgc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jgc_pkg;

    // Direction codes
    localparam logic DIR_G2J = 1'b0;
    localparam logic DIR_J2G = 1'b1;

    // Request and result items
    typedef struct packed {
        logic        req_type;
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
    } jgc_req_t;

    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic        before_epoch;
    } jgc_res_t;

    // Converted date from one of the split pipelines
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        early;
    } jgc_date_t;

    // Pipeline depths
    localparam int FRONT_LAT  = 3;
    localparam int GSPLIT_LAT = 10;
    localparam int JSPLIT_LAT = 9;
    localparam int PIPE_LAT   = FRONT_LAT + GSPLIT_LAT;

    localparam int COUNT_W = 23;

    // Calendar constants
    localparam logic [13:0] JAL_BASE      = 14'd979;
    localparam logic [13:0] GREG_BASE     = 14'd1600;
    localparam logic [22:0] EPOCH_OFS     = 23'd80;   // epoch offset plus one
    localparam logic [22:0] JAL_COUNT_OFS = 23'd78;   // epoch offset minus one

    // Reciprocals: q = (x * M) >> S, exact for the stated operand width
    localparam int          S100 = 21;   // x < 2^14
    localparam logic [15:0] M100 = 16'(((64'd1 << S100) + 64'd99) / 64'd100);
    localparam int          S400 = 23;   // x < 2^14
    localparam logic [15:0] M400 = 16'(((64'd1 << S400) + 64'd399) / 64'd400);
    localparam int          S33  = 20;   // x < 2^14
    localparam logic [15:0] M33  = 16'(((64'd1 << S33) + 64'd32) / 64'd33);
    localparam int          S12053 = 37; // x < 2^23
    localparam logic [24:0] M12053 = 25'(((64'd1 << S12053) + 64'd12052) / 64'd12053);
    localparam int          S146097 = 41; // x < 2^23
    localparam logic [24:0] M146097 = 25'(((64'd1 << S146097) + 64'd146096) / 64'd146097);
    localparam int          S36524 = 34; // x < 2^18
    localparam logic [19:0] M36524 = 20'(((64'd1 << S36524) + 64'd36523) / 64'd36524);
    localparam int          S1461 = 29;  // x < 2^18
    localparam logic [19:0] M1461 = 20'(((64'd1 << S1461) + 64'd1460) / 64'd1461);
    localparam int          S365 = 20;   // x < 2^11
    localparam logic [12:0] M365 = 13'(((64'd1 << S365) + 64'd364) / 64'd365);

    // Days before the first of each month
    localparam logic [8:0] JAL_CUM [0:11] = '{
        9'd0, 9'd31, 9'd62, 9'd93, 9'd124, 9'd155,
        9'd186, 9'd216, 9'd246, 9'd276, 9'd306, 9'd336
    };
    localparam logic [8:0] GREG_CUM [0:11] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Month code to table index; out-of-range months are clamped
    function automatic logic [3:0] month_idx(input logic [3:0] m);
        logic [3:0] idx;
        if (m == 4'd0)
            idx = 4'd0;
        else if (m > 4'd12)
            idx = 4'd11;
        else
            idx = m - 4'd1;
        return idx;
    endfunction

    // Gregorian month start including the leap day from March on
    function automatic logic [8:0] greg_thr(input logic [3:0] idx, input logic leap);
        logic [8:0] thr;
        thr = GREG_CUM[idx] + 9'((idx >= 4'd2) && leap);
        return thr;
    endfunction

endpackage

`default_nettype wire

// ===== design/jgc_day_count.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Source date to day count, three stages
module jgc_day_count
    import jgc_pkg::*;
(
    input  logic               clk,
    input  jgc_req_t           req,
    output logic [COUNT_W-1:0] count,
    output logic               dir,
    output logic               early
);

    // Stage A: year offset, quotients, month table
    logic        dir_a_reg, early_a_reg, mgt1_a_reg;
    logic [13:0] yoff_a_reg;
    logic [7:0]  q100_a_reg;
    logic [5:0]  q400_a_reg;
    logic [8:0]  q33_a_reg;
    logic [8:0]  cum_a_reg;
    logic [4:0]  day_a_reg;

    logic [13:0] yoff_next;
    logic        early_next;
    logic [3:0]  mi;
    logic [31:0] p100, p400, p33;
    logic [8:0]  cum_next;

    always_comb
    begin
        mi = month_idx(req.in_month);
        if (req.req_type == DIR_J2G)
        begin
            yoff_next  = req.in_year - JAL_BASE;
            early_next = req.in_year < JAL_BASE;
            cum_next   = JAL_CUM[mi];
        end
        else
        begin
            yoff_next  = req.in_year - GREG_BASE;
            early_next = req.in_year < GREG_BASE;
            cum_next   = GREG_CUM[mi];
        end
        p100 = 32'(yoff_next) * 32'(M100);
        p400 = 32'(yoff_next) * 32'(M400);
        p33  = 32'(yoff_next) * 32'(M33);
    end

    always_ff @(posedge clk)
    begin
        dir_a_reg   <= req.req_type;
        early_a_reg <= early_next;
        yoff_a_reg  <= yoff_next;
        q100_a_reg  <= p100[S100 +: 8];
        q400_a_reg  <= p400[S400 +: 6];
        q33_a_reg   <= p33[S33 +: 9];
        cum_a_reg   <= cum_next;
        mgt1_a_reg  <= mi > 4'd1;
        day_a_reg   <= req.in_day;
    end

    // Stage B: remainders, leap test, year days
    logic        dir_b_reg, early_b_reg;
    logic [22:0] y365_b_reg;
    logic [12:0] adj_b_reg;
    logic [8:0]  cum_b_reg;
    logic [4:0]  day_b_reg;

    logic [13:0] r100, r400, r33;
    logic        nz100, nz400, nz4, leap;
    logic [12:0] gadj, jadj;
    logic [6:0]  r33p;

    always_comb
    begin
        r100  = yoff_a_reg - 14'(14'(q100_a_reg) * 14'd100);
        r400  = yoff_a_reg - 14'(14'(q400_a_reg) * 14'd400);
        r33   = yoff_a_reg - 14'(14'(q33_a_reg) * 14'd33);
        nz100 = |r100;
        nz400 = |r400;
        nz4   = |yoff_a_reg[1:0];
        leap  = !nz4 && (nz100 || !nz400);
        gadj  = 13'(yoff_a_reg[13:2]) + 13'(nz4) - 13'(q100_a_reg) - 13'(nz100)
              + 13'(q400_a_reg) + 13'(nz400) + 13'(leap && mgt1_a_reg);
        r33p  = 7'(r33[5:0]) + 7'd3;
        jadj  = 13'({q33_a_reg, 3'b000}) + 13'(r33p[6:2]);
    end

    always_ff @(posedge clk)
    begin
        dir_b_reg   <= dir_a_reg;
        early_b_reg <= early_a_reg;
        y365_b_reg  <= 23'(yoff_a_reg) * 23'd365;
        adj_b_reg   <= (dir_a_reg == DIR_J2G) ? jadj : gadj;
        cum_b_reg   <= cum_a_reg;
        day_b_reg   <= day_a_reg;
    end

    // Stage C: final sum
    logic [22:0] count_c_reg;
    logic        dir_c_reg, early_c_reg;

    always_ff @(posedge clk)
    begin
        count_c_reg <= y365_b_reg + 23'(adj_b_reg) + 23'(cum_b_reg) + 23'(day_b_reg)
                     + ((dir_b_reg == DIR_J2G) ? JAL_COUNT_OFS : 23'd0);
        dir_c_reg   <= dir_b_reg;
        early_c_reg <= early_b_reg;
    end

    assign count = count_c_reg;
    assign dir   = dir_c_reg;
    assign early = early_c_reg;

endmodule

`default_nettype wire

// ===== design/jgc_jal_split.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Day count to Jalali date, rebased onto the epoch in S0
module jgc_jal_split
    import jgc_pkg::*;
(
    input  logic               clk,
    input  logic [COUNT_W-1:0] count,
    output jgc_date_t          date
);

    logic [JSPLIT_LAT-2:0] low_reg;

    // S0: rebase onto the epoch
    logic [22:0] jd0_reg;
    always_ff @(posedge clk)
    begin
        jd0_reg <= count - EPOCH_OFS;
        low_reg <= {low_reg[JSPLIT_LAT-3:0], count < EPOCH_OFS};
    end

    // S1: 33-year cycles
    logic [22:0] jd1_reg;
    logic [8:0]  q1_reg;
    logic [47:0] p1;
    assign p1 = 48'(jd0_reg) * 48'(M12053);
    always_ff @(posedge clk)
    begin
        jd1_reg <= jd0_reg;
        q1_reg  <= p1[S12053 +: 9];
    end

    // S2: remainder in the cycle
    logic [13:0] r1_2_reg, jy2_reg;
    always_ff @(posedge clk)
    begin
        r1_2_reg <= 14'(jd1_reg - 23'(q1_reg) * 23'd12053);
        jy2_reg  <= JAL_BASE + 14'(14'(q1_reg) * 14'd33);
    end

    // S3: 4-year groups
    logic [13:0] r1_3_reg, jy3_reg;
    logic [3:0]  q2_3_reg;
    logic [47:0] p3;
    assign p3 = 48'(r1_2_reg) * 48'(M1461);
    always_ff @(posedge clk)
    begin
        r1_3_reg <= r1_2_reg;
        jy3_reg  <= jy2_reg;
        q2_3_reg <= p3[S1461 +: 4];
    end

    // S4: remainder in the group
    logic [10:0] r2_4_reg;
    logic [13:0] jy4_reg;
    always_ff @(posedge clk)
    begin
        r2_4_reg <= 11'(r1_3_reg - 14'(q2_3_reg) * 14'd1461);
        jy4_reg  <= jy3_reg + 14'({q2_3_reg, 2'b00});
    end

    // S5: years after the leading leap year
    logic [10:0] t5_reg, t5;
    logic [1:0]  q3_5_reg;
    logic [13:0] jy5_reg;
    logic [31:0] p5;
    logic        ovr5;
    always_comb
    begin
        ovr5 = r2_4_reg >= 11'd366;
        t5   = ovr5 ? r2_4_reg - 11'd1 : r2_4_reg;
        p5   = 32'(t5) * 32'(M365);
    end
    always_ff @(posedge clk)
    begin
        t5_reg   <= t5;
        q3_5_reg <= ovr5 ? p5[S365 +: 2] : 2'd0;
        jy5_reg  <= jy4_reg;
    end

    // S6: day of year
    logic [8:0]  r3_6_reg;
    logic [13:0] jy6_reg;
    always_ff @(posedge clk)
    begin
        r3_6_reg <= 9'(t5_reg - 11'(q3_5_reg) * 11'd365);
        jy6_reg  <= jy5_reg + 14'(q3_5_reg);
    end

    // S7: month search over the start table
    logic [3:0]  idx7, idx7_reg;
    logic [8:0]  r3_7_reg;
    logic [13:0] jy7_reg;
    always_comb
    begin
        idx7 = 4'd0;
        for (int k = 1; k < 12; k++)
            idx7 = idx7 + 4'(r3_6_reg >= JAL_CUM[k]);
    end
    always_ff @(posedge clk)
    begin
        idx7_reg <= idx7;
        r3_7_reg <= r3_6_reg;
        jy7_reg  <= jy6_reg;
    end

    // S8: day of month
    jgc_date_t date_reg;
    always_ff @(posedge clk)
    begin
        date_reg.year  <= jy7_reg;
        date_reg.month <= idx7_reg + 4'd1;
        date_reg.day   <= 5'(r3_7_reg - JAL_CUM[idx7_reg] + 9'd1);
        date_reg.early <= low_reg[JSPLIT_LAT-2];
    end

    assign date = date_reg;

endmodule

`default_nettype wire

// ===== design/jgc_greg_split.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Day count since 1600-01-01 to Gregorian date
module jgc_greg_split
    import jgc_pkg::*;
(
    input  logic               clk,
    input  logic [COUNT_W-1:0] count,
    output jgc_date_t          date
);

    // S1: 400-year cycles
    logic [22:0] n1_reg;
    logic [5:0]  q1_reg;
    logic [47:0] p1;
    assign p1 = 48'(count) * 48'(M146097);
    always_ff @(posedge clk)
    begin
        n1_reg <= count;
        q1_reg <= p1[S146097 +: 6];
    end

    // S2: remainder in the cycle
    logic [17:0] r1_2_reg;
    logic [13:0] gy2_reg;
    always_ff @(posedge clk)
    begin
        r1_2_reg <= 18'(n1_reg - 23'(q1_reg) * 23'd146097);
        gy2_reg  <= GREG_BASE + 14'(14'(q1_reg) * 14'd400);
    end

    // S3: centuries after the first
    logic        big3, big3_reg;
    logic [17:0] t3, t3_reg;
    logic [47:0] p3;
    logic [1:0]  q2_3_reg;
    logic [13:0] gy3_reg;
    always_comb
    begin
        big3 = r1_2_reg >= 18'd36525;
        t3   = big3 ? r1_2_reg - 18'd1 : r1_2_reg;
        p3   = 48'(t3) * 48'(M36524);
    end
    always_ff @(posedge clk)
    begin
        big3_reg <= big3;
        t3_reg   <= t3;
        q2_3_reg <= big3 ? p3[S36524 +: 2] : 2'd0;
        gy3_reg  <= gy2_reg;
    end

    // S4: remainder in the century, century leap rule
    logic [15:0] rr4, r4, r4_reg;
    logic        leap4, leap4_reg;
    logic [13:0] gy4_reg;
    always_comb
    begin
        rr4   = 16'(t3_reg - 18'(q2_3_reg) * 18'd36524);
        r4    = rr4;
        leap4 = 1'b1;
        if (big3_reg)
        begin
            if (rr4 >= 16'd365)
                r4 = rr4 + 16'd1;
            else
                leap4 = 1'b0;
        end
    end
    always_ff @(posedge clk)
    begin
        r4_reg    <= r4;
        leap4_reg <= leap4;
        gy4_reg   <= gy3_reg + 14'(14'(q2_3_reg) * 14'd100);
    end

    // S5: 4-year groups
    logic [15:0] r5_reg;
    logic [4:0]  q3_5_reg;
    logic        leap5_reg;
    logic [13:0] gy5_reg;
    logic [47:0] p5;
    assign p5 = 48'(r4_reg) * 48'(M1461);
    always_ff @(posedge clk)
    begin
        r5_reg    <= r4_reg;
        q3_5_reg  <= p5[S1461 +: 5];
        leap5_reg <= leap4_reg;
        gy5_reg   <= gy4_reg;
    end

    // S6: remainder in the group
    logic [10:0] r6_reg;
    logic        leap6_reg;
    logic [13:0] gy6_reg;
    always_ff @(posedge clk)
    begin
        r6_reg    <= 11'(r5_reg - 16'(q3_5_reg) * 16'd1461);
        leap6_reg <= leap5_reg;
        gy6_reg   <= gy5_reg + 14'({q3_5_reg, 2'b00});
    end

    // S7: years after the leading leap year
    logic        ovr7, leap7_reg;
    logic [10:0] t7, t7_reg;
    logic [31:0] p7;
    logic [1:0]  q4_7_reg;
    logic [13:0] gy7_reg;
    always_comb
    begin
        ovr7 = r6_reg >= 11'd366;
        t7   = ovr7 ? r6_reg - 11'd1 : r6_reg;
        p7   = 32'(t7) * 32'(M365);
    end
    always_ff @(posedge clk)
    begin
        t7_reg    <= t7;
        q4_7_reg  <= ovr7 ? p7[S365 +: 2] : 2'd0;
        leap7_reg <= leap6_reg && !ovr7;
        gy7_reg   <= gy6_reg;
    end

    // S8: day of year
    logic [8:0]  r8_reg;
    logic        leap8_reg;
    logic [13:0] gy8_reg;
    always_ff @(posedge clk)
    begin
        r8_reg    <= 9'(t7_reg - 11'(q4_7_reg) * 11'd365);
        leap8_reg <= leap7_reg;
        gy8_reg   <= gy7_reg + 14'(q4_7_reg);
    end

    // S9: month search
    logic [3:0]  idx9, idx9_reg;
    logic [8:0]  r9_reg;
    logic        leap9_reg;
    logic [13:0] gy9_reg;
    always_comb
    begin
        idx9 = 4'd0;
        for (int k = 1; k < 12; k++)
            idx9 = idx9 + 4'(r8_reg >= greg_thr(4'(k), leap8_reg));
    end
    always_ff @(posedge clk)
    begin
        idx9_reg  <= idx9;
        r9_reg    <= r8_reg;
        leap9_reg <= leap8_reg;
        gy9_reg   <= gy8_reg;
    end

    // S10: day of month
    jgc_date_t date_reg;
    always_ff @(posedge clk)
    begin
        date_reg.year  <= gy9_reg;
        date_reg.month <= idx9_reg + 4'd1;
        date_reg.day   <= 5'(r9_reg - greg_thr(idx9_reg, leap9_reg) + 9'd1);
        date_reg.early <= 1'b0;
    end

    assign date = date_reg;

endmodule

`default_nettype wire

// ===== design/jalali_gregorian_date_converter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Gregorian/Jalali date converter. One item may be started in every clock
// cycle; busy is always low. Each item's result appears on res with strobe
// high for exactly one cycle, once the item has gone through 3 stages of day
// counting, 10 stages splitting the count back into a date through the
// 400-year, century, 4-year and month steps, and the output register.
// Results come out in start order and cannot be held off, so the receiver
// must take every strobe. before_epoch is set, with a zero date, for
// Gregorian dates before 1600-03-20 and Jalali years below 979.
module jalali_gregorian_date_converter_unit
    import jgc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  jgc_req_t req,
    output logic     strobe,
    output jgc_res_t res
);

    typedef struct packed {
        logic dir;
        logic early;
    } jgc_side_t;

    logic [COUNT_W-1:0] count;
    logic               dir_c, early_c;
    jgc_date_t          jdate, gdate;

    jgc_day_count u_count (
        .clk   (clk),
        .req   (req),
        .count (count),
        .dir   (dir_c),
        .early (early_c)
    );

    jgc_jal_split u_jal (
        .clk   (clk),
        .count (count),
        .date  (jdate)
    );

    jgc_greg_split u_greg (
        .clk   (clk),
        .count (count),
        .date  (gdate)
    );

    assign busy = 1'b0;

    // Item valid flags along the pipeline
    logic [PIPE_LAT-1:0] valid_reg;
    logic                strobe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= {valid_reg[PIPE_LAT-2:0], start && !busy};
            strobe_reg <= valid_reg[PIPE_LAT-1];
        end
    end

    // Direction and year flag alongside the split stages; Jalali result realigned
    jgc_side_t side_reg [GSPLIT_LAT];
    jgc_date_t jdate_reg;

    always_ff @(posedge clk)
    begin
        side_reg[0] <= '{dir: dir_c, early: early_c};
        for (int i = 1; i < GSPLIT_LAT; i++)
            side_reg[i] <= side_reg[i-1];
        jdate_reg <= jdate;
    end

    // Output register
    jgc_res_t  res_reg;
    jgc_side_t side_o;
    logic      early_o;

    always_comb
    begin
        side_o  = side_reg[GSPLIT_LAT-1];
        early_o = side_o.early || ((side_o.dir == DIR_G2J) && jdate_reg.early);
    end

    always_ff @(posedge clk)
    begin
        if (early_o)
        begin
            res_reg <= '{out_year: 14'd0, out_month: 4'd0,
                         out_day: 5'd0, before_epoch: 1'b1};
        end
        else if (side_o.dir == DIR_J2G)
        begin
            res_reg <= '{out_year: gdate.year, out_month: gdate.month,
                         out_day: gdate.day, before_epoch: 1'b0};
        end
        else
        begin
            res_reg <= '{out_year: jdate_reg.year, out_month: jdate_reg.month,
                         out_day: jdate_reg.day, before_epoch: 1'b0};
        end
    end

    assign strobe = strobe_reg;
    assign res    = res_reg;

    // Every strobe goes back to a taken start
    a_strobe_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start, PIPE_LAT + 1))
        else $error("result without a started item");

    // Early dates carry an all-zero date
    a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && res.before_epoch |->
            res.out_year == 14'd0 && res.out_month == 4'd0 && res.out_day == 5'd0)
        else $error("early date with non-zero fields");

    // Converted dates have a sane month and a non-zero day
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !res.before_epoch |->
            res.out_month >= 4'd1 && res.out_month <= 4'd12 && res.out_day != 5'd0)
        else $error("converted month or day out of range");

endmodule

`default_nettype wire
